// File: rtl/core/nbs_pkg.sv
`timescale 1ns / 1ps

package nbs_pkg;

    // lookahead depth: longest recognised branch is six bytes
    localparam int LOOKAHEAD_BYTES = 6;
    localparam int AVAIL_W         = $clog2(LOOKAHEAD_BYTES + 1);

    // opcode bytes
    localparam logic [7:0] OP_CALL_NEAR    = 8'hE8;
    localparam logic [7:0] OP_JMP_NEAR     = 8'hE9;
    localparam logic [7:0] OP_JMP_SHORT    = 8'hEB;
    localparam logic [7:0] OP_JCC_SHORT_LO = 8'h70;
    localparam logic [7:0] OP_JCC_SHORT_HI = 8'h7F;
    localparam logic [7:0] OP_TWO_BYTE     = 8'h0F;
    localparam logic [7:0] OP_JCC_NEAR_LO  = 8'h80;
    localparam logic [7:0] OP_JCC_NEAR_HI  = 8'h8F;

    // instruction lengths in bytes
    localparam logic [AVAIL_W-1:0] LEN_SHORT    = AVAIL_W'(2);
    localparam logic [AVAIL_W-1:0] LEN_NEAR     = AVAIL_W'(5);
    localparam logic [AVAIL_W-1:0] LEN_JCC_NEAR = AVAIL_W'(6);

    // register indexes
    localparam logic [1:0] CFG_IMAGE_BASE    = 2'd0;
    localparam logic [1:0] CFG_WINDOW_START  = 2'd1;
    localparam logic [1:0] CFG_WINDOW_LENGTH = 2'd2;
    localparam logic [1:0] CFG_MAX_REPORTED  = 2'd3;

    // result kinds
    localparam logic KIND_BRANCH  = 1'b0;
    localparam logic KIND_SUMMARY = 1'b1;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       is_last;
    } in_item_t;

    typedef struct packed {
        logic        kind;
        logic [31:0] site_offset;
        logic [7:0]  branch_opcode;
        logic        rel32_form;
        logic [31:0] dest_address;
        logic [31:0] total_found;
        logic        was_capped;
        logic        last_result;
    } out_item_t;

    typedef struct packed {
        logic [1:0]  index;
        logic [31:0] data;
    } cfg_item_t;

    typedef struct packed {
        logic [31:0] image_base;
        logic [31:0] window_start;
        logic [31:0] window_length;
        logic [31:0] max_reported;
    } cfg_regs_t;

    // one offset to decide, or the end-of-scan marker
    typedef struct packed {
        logic                                valid;
        logic                                summary;
        logic [31:0]                         offset;
        logic [LOOKAHEAD_BYTES-1:0][7:0]     bytes;
        logic [AVAIL_W-1:0]                  avail;
    } cand_t;

    typedef struct packed {
        logic [31:0] found_count;
        logic [31:0] emitted_count;
    } scan_stat_t;

endpackage

// File: rtl/core/nbs_stream_if.sv
`timescale 1ns / 1ps

interface nbs_stream_if #(parameter type payload_t = logic) ();
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// File: rtl/core/nbs_front.sv
`timescale 1ns / 1ps

module nbs_front
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  nbs_pkg::in_item_t   in_item,
    output logic                in_ready,
    input  logic                cand_take,
    output nbs_pkg::cand_t      cand
);

    localparam int LA = nbs_pkg::LOOKAHEAD_BYTES;
    localparam int AW = nbs_pkg::AVAIL_W;

    logic [LA-1:0][7:0] win_reg;
    logic [AW-1:0]      fill_reg;
    logic [31:0]        pos_reg;
    logic               flush_reg;
    logic [AW-1:0]      step_reg;
    nbs_pkg::cand_t     cand_reg;

    logic               cand_free;
    logic               accept;
    logic [LA-1:0][7:0] shifted;
    logic [AW-1:0]      fill_inc;
    logic [LA-1:0][7:0] tail_bytes;
    logic [AW-1:0]      tail_idx [LA];

    assign cand_free = !cand_reg.valid || cand_take;
    assign in_ready  = !flush_reg && cand_free;
    assign accept    = in_valid && in_ready;
    assign cand      = cand_reg;

    // window after shifting in the new byte
    always_comb
    begin
        for (int i = 0; i < LA - 1; i++)
        begin
            shifted[i] = win_reg[i + 1];
        end
        shifted[LA-1] = in_item.data_byte;
    end

    assign fill_inc = (fill_reg == AW'(LA)) ? fill_reg : fill_reg + AW'(1);

    // last step_reg bytes of the window, zero padded
    always_comb
    begin
        for (int i = 0; i < LA; i++)
        begin
            tail_idx[i] = AW'(LA) - step_reg + AW'(i);
            if (AW'(i) < step_reg)
            begin
                tail_bytes[i] = win_reg[tail_idx[i]];
            end
            else
            begin
                tail_bytes[i] = 8'h00;
            end
        end
    end

    // byte intake and end-of-buffer flush sequencing
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_reg        <= '0;
            fill_reg       <= '0;
            pos_reg        <= '0;
            flush_reg      <= 1'b0;
            step_reg       <= '0;
            cand_reg       <= '0;
        end
        else if (accept)
        begin
            win_reg  <= shifted;
            fill_reg <= fill_inc;
            if (in_item.is_last)
            begin
                flush_reg      <= 1'b1;
                step_reg       <= fill_inc;
                cand_reg.valid <= 1'b0;
            end
            else
            begin
                pos_reg          <= pos_reg + 32'd1;
                cand_reg.valid   <= (fill_inc == AW'(LA));
                cand_reg.summary <= 1'b0;
                cand_reg.offset  <= pos_reg - 32'(LA - 1);
                cand_reg.bytes   <= shifted;
                cand_reg.avail   <= AW'(LA);
            end
        end
        else if (flush_reg && cand_free)
        begin
            cand_reg.valid <= 1'b1;
            cand_reg.bytes <= tail_bytes;
            cand_reg.avail <= step_reg;
            cand_reg.offset <= pos_reg - 32'(step_reg) + 32'd1;
            if (step_reg != '0)
            begin
                cand_reg.summary <= 1'b0;
                step_reg         <= step_reg - AW'(1);
            end
            else
            begin
                // summary goes out, scan state back to its reset values
                cand_reg.summary <= 1'b1;
                flush_reg        <= 1'b0;
                win_reg          <= '0;
                fill_reg         <= '0;
                pos_reg          <= '0;
            end
        end
        else if (cand_take)
        begin
            cand_reg.valid <= 1'b0;
        end
    end

endmodule

// File: rtl/core/nbs_decide.sv
`timescale 1ns / 1ps

module nbs_decide
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  nbs_pkg::cfg_regs_t   cfg_regs,
    input  nbs_pkg::cand_t       cand,
    output logic                 cand_take,
    output logic                 out_valid,
    input  logic                 out_ready,
    output nbs_pkg::out_item_t   out_item,
    output nbs_pkg::scan_stat_t  stat
);

    localparam int AW = nbs_pkg::AVAIL_W;

    logic [31:0]        found_reg;
    logic [31:0]        emitted_reg;
    logic               cap_reg;
    logic               out_valid_reg;
    logic               out_valid_next;
    nbs_pkg::out_item_t out_item_reg;

    logic [32:0]   wend;
    logic [32:0]   off_ext;
    logic          in_win;
    logic          second_in;
    logic [7:0]    op;
    logic [7:0]    op2;
    logic          is_near;
    logic          is_short;
    logic          is_jcc_near;
    logic [AW-1:0] len;
    logic [31:0]   rel;
    logic [31:0]   target;
    logic          hit;
    logic          emit;

    assign cand_take = cand.valid && (!out_valid_reg || out_ready);
    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;
    assign stat      = '{found_count: found_reg, emitted_count: emitted_reg};

    // window test, computed without wrap
    assign wend      = {1'b0, cfg_regs.window_start} + {1'b0, cfg_regs.window_length};
    assign off_ext   = {1'b0, cand.offset};
    assign in_win    = (cand.offset >= cfg_regs.window_start) && (off_ext < wend);
    assign second_in = (off_ext + 33'd1) < wend;

    // opcode decode
    assign op          = cand.bytes[0];
    assign op2         = cand.bytes[1];
    assign is_near     = (op == nbs_pkg::OP_CALL_NEAR) || (op == nbs_pkg::OP_JMP_NEAR);
    assign is_short    = (op == nbs_pkg::OP_JMP_SHORT) ||
                         ((op >= nbs_pkg::OP_JCC_SHORT_LO) && (op <= nbs_pkg::OP_JCC_SHORT_HI));
    assign is_jcc_near = (op == nbs_pkg::OP_TWO_BYTE) && (cand.avail >= AW'(2)) && second_in &&
                         (op2 >= nbs_pkg::OP_JCC_NEAR_LO) && (op2 <= nbs_pkg::OP_JCC_NEAR_HI);

    // length and displacement
    always_comb
    begin
        if (is_near)
        begin
            len = nbs_pkg::LEN_NEAR;
            rel = {cand.bytes[4], cand.bytes[3], cand.bytes[2], cand.bytes[1]};
        end
        else if (is_short)
        begin
            len = nbs_pkg::LEN_SHORT;
            rel = {{24{op2[7]}}, op2};
        end
        else
        begin
            len = nbs_pkg::LEN_JCC_NEAR;
            rel = {cand.bytes[5], cand.bytes[4], cand.bytes[3], cand.bytes[2]};
        end
    end

    assign target = cfg_regs.image_base + cand.offset + 32'(len) + rel;
    assign hit    = !cand.summary && in_win && (is_near || is_short || is_jcc_near) &&
                    (len <= cand.avail);
    assign emit   = hit && (emitted_reg < cfg_regs.max_reported);

    // result valid: dropped once taken, raised by a new record or summary
    always_comb
    begin
        out_valid_next = out_valid_reg && !out_ready;
        if (cand_take && (cand.summary || emit))
        begin
            out_valid_next = 1'b1;
        end
    end

    // counters and result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            found_reg     <= '0;
            emitted_reg   <= '0;
            cap_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (cand_take)
            begin
                if (cand.summary)
                begin
                    out_item_reg  <= '{kind: nbs_pkg::KIND_SUMMARY, site_offset: 32'd0,
                                       branch_opcode: 8'd0, rel32_form: 1'b0,
                                       dest_address: 32'd0, total_found: found_reg,
                                       was_capped: cap_reg, last_result: 1'b1};
                    found_reg     <= '0;
                    emitted_reg   <= '0;
                    cap_reg       <= 1'b0;
                end
                else if (hit)
                begin
                    if (found_reg != 32'hFFFF_FFFF)
                    begin
                        found_reg <= found_reg + 32'd1;
                    end
                    if (emit)
                    begin
                        emitted_reg   <= emitted_reg + 32'd1;
                        out_item_reg  <= '{kind: nbs_pkg::KIND_BRANCH,
                                           site_offset: cand.offset,
                                           branch_opcode: is_jcc_near ? op2 : op,
                                           rel32_form: is_near || is_jcc_near,
                                           dest_address: target, total_found: 32'd0,
                                           was_capped: 1'b0, last_result: 1'b0};
                    end
                    else
                    begin
                        cap_reg <= 1'b1;
                    end
                end
            end
        end
    end

endmodule

// File: rtl/core/x86_near_branch_scanner_unit.sv
`timescale 1ns / 1ps

// channel  role  payload                                  transaction
// code     sink  data_byte, is_last                       one buffer byte
// result   src   kind, site_offset, branch_opcode, ...    one branch record or summary
// cfg      sink  index, data                              one register write
//
// one byte per cycle unless the result stalls or a flush runs; a window is decided once registered
// a record passes the candidate register and then the result register before it leaves
// after the last byte, intake pauses while the flush walks the up to six pending
// offsets and then the summary, one a cycle while the result is not stalled
// reset clears counters, window and flush state; configuration registers return to zero
// a stalled result holds the decoder and, once the candidate register is full, the byte intake

module x86_near_branch_scanner_unit
(
    input logic          clk,
    input logic          rst_n,
    nbs_stream_if.sink   code,
    nbs_stream_if.source result,
    nbs_stream_if.sink   cfg
);

    nbs_pkg::cfg_regs_t  cfg_regs_reg;
    nbs_pkg::cand_t      cand;
    logic                cand_take;
    nbs_pkg::scan_stat_t stat;
    nbs_pkg::in_item_t   in_item;
    nbs_pkg::cfg_item_t  cfg_item;
    nbs_pkg::out_item_t  out_item;

    assign in_item        = code.payload;
    assign cfg_item       = cfg.payload;
    assign result.payload = out_item;
    assign cfg.ready      = 1'b1;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_regs_reg <= '0;
        end
        else if (cfg.valid)
        begin
            case (cfg_item.index)
                nbs_pkg::CFG_IMAGE_BASE:    cfg_regs_reg.image_base    <= cfg_item.data;
                nbs_pkg::CFG_WINDOW_START:  cfg_regs_reg.window_start  <= cfg_item.data;
                nbs_pkg::CFG_WINDOW_LENGTH: cfg_regs_reg.window_length <= cfg_item.data;
                nbs_pkg::CFG_MAX_REPORTED:  cfg_regs_reg.max_reported  <= cfg_item.data;
                default:
                begin
                end
            endcase
        end
    end

    // byte window and flush sequencer
    nbs_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (code.valid),
        .in_item   (in_item),
        .in_ready  (code.ready),
        .cand_take (cand_take),
        .cand      (cand)
    );

    // branch decode, counting and result register
    nbs_decide u_decide
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_regs  (cfg_regs_reg),
        .cand      (cand),
        .cand_take (cand_take),
        .out_valid (result.valid),
        .out_ready (result.ready),
        .out_item  (out_item),
        .stat      (stat)
    );

    // a last byte starts the flush, which blocks intake
    a_flush_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        (code.valid && code.ready && in_item.is_last) |=> !code.ready)
        else $error("byte taken during end-of-scan flush");

    // records emitted never outnumber branches found
    a_emit_le_found: assert property (@(posedge clk) disable iff (!rst_n)
        stat.emitted_count <= stat.found_count)
        else $error("emitted count exceeds found count");

    // a waiting summary means the counters were already cleared
    a_summary_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && out_item.last_result) |->
            (stat.found_count == 32'd0 && stat.emitted_count == 32'd0))
        else $error("scan counters not cleared with summary");

endmodule
